/* rtl/chained_hash_table_unit_assert.svh */
// Assertion macros shared by the chained hash table RTL.
// Included by modules that check their own control logic; no dependencies.
`ifndef CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CHT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("chained hash table check failed");

// Next-cycle implication, disabled while reset is held.
`define CHT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("chained hash table check failed");

`endif

/* rtl/cht_pkg.sv */
// Package for the chained hash table: field widths, action and status codes.
// No dependencies; used by cht_hash, the top level and the testbench.
package cht_pkg;

    localparam int ACTION_W  = 2;
    localparam int KEY_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int BUCKET_W  = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam int DIGIT_W = 8;
    localparam int DIGITS  = KEY_W / DIGIT_W;
    localparam int CNT_W   = 3;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_SEARCH = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;

    localparam status_t STAT_OK   = 2'd0;
    localparam status_t STAT_MISS = 2'd1;
    localparam status_t STAT_FULL = 2'd2;

endpackage

/* rtl/cht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/cht_hash.sv */
// Bucket hash unit: signed key modulo BUCKETS, non-negative, one byte a cycle.
// Depends on cht_pkg.
module cht_hash #(
    parameter int BUCKETS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  cht_pkg::key_t         key,
    output logic                  done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

    localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW  = $clog2(BUCKETS + 1) + 1;
    localparam logic [63:0]   WRAP64   = (64'd1 << cht_pkg::KEY_W) % 64'(BUCKETS);
    localparam logic [RW-1:0] WRAP_MOD = WRAP64[RW-1:0];
    localparam logic [RW-1:0] B_RW     = RW'(BUCKETS);
    localparam logic [cht_pkg::CNT_W-1:0] LAST_CNT = cht_pkg::CNT_W'(cht_pkg::DIGITS);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [cht_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]             rem_reg, rem_next;
    cht_pkg::key_t             shift_reg, shift_next;
    logic                      neg_reg, neg_next;
    logic [RW-1:0]             digit_rem;
    logic [RW-1:0]             fixed_rem;

    always_comb begin
        logic [RW-1:0] t;
        t = rem_reg;
        for (int i = 0; i < cht_pkg::DIGIT_W; i++) begin
            t = {t[RW-2:0], shift_reg[cht_pkg::KEY_W-1-i]};
            if (t >= B_RW) begin
                t = t - B_RW;
            end
        end
        digit_rem = t;
    end

    // A negative key is its bit pattern less two to the power of the key width.
    always_comb begin
        if (!neg_reg) begin
            fixed_rem = rem_reg;
        end else if (rem_reg >= WRAP_MOD) begin
            fixed_rem = rem_reg - WRAP_MOD;
        end else begin
            fixed_rem = rem_reg + B_RW - WRAP_MOD;
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        neg_next   = neg_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            shift_next = key;
            neg_next   = key[cht_pkg::KEY_W-1];
        end else if (busy_reg) begin
            if (cnt_reg == LAST_CNT) begin
                rem_next  = fixed_rem;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                rem_next   = digit_rem;
                shift_next = {shift_reg[cht_pkg::KEY_W-cht_pkg::DIGIT_W-1:0],
                              {cht_pkg::DIGIT_W{1'b0}}};
                cnt_next   = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        neg_reg   <= neg_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg[BKW-1:0];

endmodule

/* rtl/chained_hash_table_unit.sv */
// Chained hash table unit: top level with request sequencer and bucket heads.
// Depends on cht_pkg, cht_hash, cht_ram and chained_hash_table_unit_assert.svh.
//
// Use: each request on the s_ channel carries an action (insert, search,
// delete) and a signed key; each request gives exactly one result on the m_
// channel with a status and the bucket the key hashed to.
// The key is hashed one byte a cycle, then the chain is read from the entry
// memory one entry a cycle. An insert takes its entry from the free stack
// when that is not empty, else the next never-used pool entry, and writes it
// at the head of the chain; a search or delete walks the chain until the key
// is found or the chain ends, and a full pool or an unused action goes
// straight to the result. One request is worked on at a time, and the next is
// accepted in the cycle after the result is loaded into the output register.
// The entry memory's single read port sets the walk rate.
// At reset all chains are empty and the pool is wholly unused; no clearing
// pass is needed. If the receiver stalls, the result waits in the output
// register, the next request is still accepted and worked on, and it is
// held at its end until the output register is free.
`include "chained_hash_table_unit_assert.svh"
module chained_hash_table_unit #(
    parameter int BUCKETS      = 10,
    parameter int POOL_ENTRIES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cht_pkg::S_TDATA_W-1:0] s_tdata,  // action[1:0], key[33:2], zeros
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cht_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], bucket[5:2], zeros
);

    localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW  = $clog2(POOL_ENTRIES);
    localparam int PW  = $clog2(POOL_ENTRIES + 1);
    localparam int EW  = cht_pkg::KEY_W + PW;
    localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HASH = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;
    localparam logic [2:0] ST_POP  = 3'd3;
    localparam logic [2:0] ST_INS  = 3'd4;
    localparam logic [2:0] ST_WALK = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]              state_reg, state_next;
    cht_pkg::action_t        act_reg, act_next;
    cht_pkg::key_t           key_reg, key_next;
    logic [BKW-1:0]          bkt_reg, bkt_next;
    logic [IW-1:0]           entry_reg, entry_next;
    logic [IW-1:0]           cur_reg, cur_next;
    logic [PW-1:0]           prev_reg, prev_next;
    cht_pkg::key_t           prev_key_reg, prev_key_next;
    logic [PW-1:0]           steps_reg, steps_next;
    logic [PW-1:0]           free_top_reg, free_top_next;
    logic [PW-1:0]           fresh_reg, fresh_next;
    cht_pkg::status_t        status_reg, status_next;
    logic [PW-1:0]           heads_reg [BUCKETS];
    logic [PW-1:0]           heads_next [BUCKETS];
    logic                    m_tvalid_reg, m_tvalid_next;
    cht_pkg::status_t        m_status_reg, m_status_next;
    logic [BKW-1:0]          m_bucket_reg, m_bucket_next;

    logic                    accept;
    logic                    hash_done;
    logic [BKW-1:0]          hash_bucket;
    logic                    ent_we;
    logic [IW-1:0]           ent_waddr, ent_raddr;
    logic [EW-1:0]           ent_wdata, ent_rdata;
    logic                    free_we;
    logic [IW-1:0]           free_waddr, free_raddr, free_rdata;
    logic [PW-1:0]           head;
    cht_pkg::key_t           rd_key;
    logic [PW-1:0]           rd_next;
    logic [PW-1:0]           free_top_dec;
    logic [PW-1:0]           steps_inc;
    logic [BKW+cht_pkg::BUCKET_W-1:0] bucket_ext;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    cht_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (s_tdata[cht_pkg::ACTION_W +: cht_pkg::KEY_W]),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    cht_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    cht_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_ENTRIES)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (free_we),
        .wr_addr (free_waddr),
        .wr_data (cur_reg),
        .rd_addr (free_raddr),
        .rd_data (free_rdata)
    );

    assign head         = heads_reg[bkt_reg];
    assign rd_key       = ent_rdata[EW-1:PW];
    assign rd_next      = ent_rdata[PW-1:0];
    assign free_top_dec = free_top_reg - 1'b1;
    assign steps_inc    = steps_reg + 1'b1;
    assign free_raddr   = free_top_dec[IW-1:0];

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        bkt_next      = bkt_reg;
        entry_next    = entry_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_key_next = prev_key_reg;
        steps_next    = steps_reg;
        free_top_next = free_top_reg;
        fresh_next    = fresh_reg;
        status_next   = status_reg;
        heads_next    = heads_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_bucket_next = m_bucket_reg;
        ent_we        = 1'b0;
        ent_waddr     = entry_reg;
        ent_wdata     = {key_reg, head};
        ent_raddr     = head[IW-1:0];
        free_we       = 1'b0;
        free_waddr    = free_top_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    act_next   = s_tdata[cht_pkg::ACTION_W-1:0];
                    key_next   = s_tdata[cht_pkg::ACTION_W +: cht_pkg::KEY_W];
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    bkt_next   = hash_bucket;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                case (act_reg) inside
                    cht_pkg::ACT_INSERT: begin
                        if (free_top_reg != '0) begin
                            free_top_next = free_top_dec;
                            state_next    = ST_POP;
                        end else if (fresh_reg != NIL) begin
                            entry_next = fresh_reg[IW-1:0];
                            fresh_next = fresh_reg + 1'b1;
                            state_next = ST_INS;
                        end else begin
                            status_next = cht_pkg::STAT_FULL;
                            state_next  = ST_DONE;
                        end
                    end
                    cht_pkg::ACT_SEARCH, cht_pkg::ACT_DELETE: begin
                        if (head >= NIL) begin
                            status_next = cht_pkg::STAT_MISS;
                            state_next  = ST_DONE;
                        end else begin
                            cur_next   = head[IW-1:0];
                            prev_next  = NIL;
                            steps_next = '0;
                            state_next = ST_WALK;
                        end
                    end
                    default: begin
                        status_next = cht_pkg::STAT_MISS;
                        state_next  = ST_DONE;
                    end
                endcase
            end
            ST_POP: begin
                entry_next = free_rdata;
                state_next = ST_INS;
            end
            ST_INS: begin
                ent_we              = 1'b1;
                heads_next[bkt_reg] = PW'(entry_reg);
                status_next         = cht_pkg::STAT_OK;
                state_next          = ST_DONE;
            end
            ST_WALK: begin
                ent_raddr = rd_next[IW-1:0];
                if (rd_key == key_reg) begin
                    status_next = cht_pkg::STAT_OK;
                    state_next  = ST_DONE;
                    if (act_reg == cht_pkg::ACT_DELETE) begin
                        if (prev_reg >= NIL) begin
                            heads_next[bkt_reg] = rd_next;
                        end else begin
                            ent_we    = 1'b1;
                            ent_waddr = prev_reg[IW-1:0];
                            ent_wdata = {prev_key_reg, rd_next};
                        end
                        if (free_top_reg < NIL) begin
                            free_we       = 1'b1;
                            free_top_next = free_top_reg + 1'b1;
                        end
                    end
                end else if (steps_inc == NIL || rd_next >= NIL) begin
                    status_next = cht_pkg::STAT_MISS;
                    state_next  = ST_DONE;
                end else begin
                    prev_next     = PW'(cur_reg);
                    prev_key_next = rd_key;
                    cur_next      = rd_next[IW-1:0];
                    steps_next    = steps_inc;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_bucket_next = bkt_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            free_top_reg <= '0;
            fresh_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) begin
                heads_reg[i] <= NIL;
            end
        end else begin
            state_reg    <= state_next;
            free_top_reg <= free_top_next;
            fresh_reg    <= fresh_next;
            m_tvalid_reg <= m_tvalid_next;
            heads_reg    <= heads_next;
        end
        act_reg      <= act_next;
        key_reg      <= key_next;
        bkt_reg      <= bkt_next;
        entry_reg    <= entry_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_key_reg <= prev_key_next;
        steps_reg    <= steps_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_bucket_reg <= m_bucket_next;
    end

    assign bucket_ext = {{cht_pkg::BUCKET_W{1'b0}}, m_bucket_reg};
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{(cht_pkg::M_TDATA_W - cht_pkg::STATUS_W - cht_pkg::BUCKET_W){1'b0}},
                         bucket_ext[cht_pkg::BUCKET_W-1:0], m_status_reg};

    `CHT_ASSERT_NOW(a_free_top_range, aclk, aresetn, 1'b1, free_top_reg <= NIL)
    `CHT_ASSERT_NOW(a_free_within_used, aclk, aresetn, 1'b1, free_top_reg <= fresh_reg)
    `CHT_ASSERT_NOW(a_entry_write_state, aclk, aresetn, ent_we,
        state_reg == ST_INS || state_reg == ST_WALK)
    `CHT_ASSERT_NOW(a_hash_done_state, aclk, aresetn, hash_done, state_reg == ST_HASH)
    `CHT_ASSERT_NEXT(a_accept_to_hash, aclk, aresetn, accept, state_reg == ST_HASH)

endmodule

/* tb/chained_hash_table_unit_tb.sv */
// Self-checking testbench for chained_hash_table_unit: random and directed requests
// are checked against a behavioural hash table kept inside the testbench.
// Depends on cht_pkg and the chained_hash_table_unit RTL only.
`timescale 1ns / 1ps

module chained_hash_table_unit_tb;

    localparam int BUCKETS      = 10;
    localparam int POOL_ENTRIES = 256;
    localparam int NIL_LINK     = POOL_ENTRIES;
    localparam int KEY_SET_SIZE = 40;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int MAX_REPORTS  = 10;

    localparam cht_pkg::action_t ACT_UNUSED = 2'd3;

    typedef struct {
        cht_pkg::action_t action;
        cht_pkg::key_t    key;
        int unsigned      gap;
    } request_t;

    typedef struct {
        cht_pkg::status_t             status;
        logic [cht_pkg::BUCKET_W-1:0] bucket;
    } reply_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [cht_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [cht_pkg::M_TDATA_W-1:0] m_tdata;

    request_t pending_requests[$];
    reply_t   expected_replies[$];

    int bucket_head[BUCKETS];
    int entry_key[POOL_ENTRIES];
    int entry_next[POOL_ENTRIES];
    int free_stack[POOL_ENTRIES];
    int free_top;
    int fresh_count;

    cht_pkg::key_t key_set[KEY_SET_SIZE];
    bit            steady;
    int unsigned   send_hold;
    int unsigned   reply_hold;
    int unsigned   replies_seen;
    int unsigned   mismatches;
    int unsigned   cycles;

    chained_hash_table_unit #(
        .BUCKETS      (BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int home_bucket(input cht_pkg::key_t key);
        int k;
        int r;
        k = $signed(key);
        r = k % BUCKETS;
        if (r < 0) begin
            r = r + BUCKETS;
        end
        return r;
    endfunction

    task automatic hash_table_update(input cht_pkg::action_t act, input cht_pkg::key_t key);
        reply_t res;
        int     b;
        int     e;
        int     cur;
        int     prev;
        int     steps;
        b          = home_bucket(key);
        res.bucket = b[cht_pkg::BUCKET_W-1:0];
        res.status = cht_pkg::STAT_MISS;
        if (act == cht_pkg::ACT_INSERT) begin
            e = -1;
            if (free_top > 0) begin
                free_top = free_top - 1;
                e = free_stack[free_top];
            end else if (fresh_count < POOL_ENTRIES) begin
                e = fresh_count;
                fresh_count = fresh_count + 1;
            end
            if (e >= 0) begin
                entry_key[e]   = key;
                entry_next[e]  = bucket_head[b];
                bucket_head[b] = e;
                res.status     = cht_pkg::STAT_OK;
            end else begin
                res.status = cht_pkg::STAT_FULL;
            end
        end else if (act == cht_pkg::ACT_SEARCH || act == cht_pkg::ACT_DELETE) begin
            cur   = bucket_head[b];
            prev  = NIL_LINK;
            steps = 0;
            while (cur < POOL_ENTRIES && steps < POOL_ENTRIES && entry_key[cur] != key) begin
                prev  = cur;
                cur   = entry_next[cur];
                steps = steps + 1;
            end
            if (cur < POOL_ENTRIES && steps < POOL_ENTRIES) begin
                res.status = cht_pkg::STAT_OK;
                if (act == cht_pkg::ACT_DELETE) begin
                    if (prev < POOL_ENTRIES) begin
                        entry_next[prev] = entry_next[cur];
                    end else begin
                        bucket_head[b] = entry_next[cur];
                    end
                    if (free_top < POOL_ENTRIES) begin
                        free_stack[free_top] = cur;
                        free_top = free_top + 1;
                    end
                end
            end
        end
        expected_replies.push_back(res);
    endtask

    task automatic queue_request(input cht_pkg::action_t act, input cht_pkg::key_t key);
        request_t req;
        req.action = act;
        req.key    = key;
        req.gap    = steady ? 0 : $urandom_range(0, 5);
        pending_requests.push_back(req);
    endtask

    function automatic cht_pkg::key_t pick_key();
        if ($urandom_range(0, 9) < 7) begin
            return key_set[$urandom_range(0, KEY_SET_SIZE - 1)];
        end
        return cht_pkg::key_t'($urandom);
    endfunction

    task automatic queue_random(input int count, input int ins_pct, input int srch_pct,
                                input int del_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                queue_request(cht_pkg::ACT_INSERT, pick_key());
            end else if (r < ins_pct + srch_pct) begin
                queue_request(cht_pkg::ACT_SEARCH, pick_key());
            end else if (r < ins_pct + srch_pct + del_pct) begin
                queue_request(cht_pkg::ACT_DELETE, pick_key());
            end else begin
                queue_request(ACT_UNUSED, pick_key());
            end
        end
    endtask

    // Driver: the gap stored with each request is spent before it is presented.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_hold = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                hash_table_update(
                    cht_pkg::action_t'(s_tdata[cht_pkg::ACTION_W-1:0]),
                    cht_pkg::key_t'(s_tdata[cht_pkg::ACTION_W +: cht_pkg::KEY_W]));
            end
            if (pending_requests.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (send_hold < pending_requests[0].gap) begin
                send_hold = send_hold + 1;
                s_tvalid  <= 1'b0;
            end else begin
                request_t req;
                req       = pending_requests.pop_front();
                send_hold = 0;
                s_tvalid  <= 1'b1;
                s_tdata   <= {{(cht_pkg::S_TDATA_W - cht_pkg::KEY_W - cht_pkg::ACTION_W){1'b0}},
                              req.key, req.action};
            end
        end
    end

    // Monitor: compares each reply with the oldest expectation and paces m_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            reply_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                replies_seen = replies_seen + 1;
                if (expected_replies.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Unexpected reply: status %0d bucket %0d",
                                 m_tdata[cht_pkg::STATUS_W-1:0],
                                 m_tdata[cht_pkg::STATUS_W +: cht_pkg::BUCKET_W]);
                    end
                end else begin
                    reply_t exp_res;
                    exp_res = expected_replies.pop_front();
                    if (m_tdata[cht_pkg::STATUS_W-1:0] !== exp_res.status ||
                        m_tdata[cht_pkg::STATUS_W +: cht_pkg::BUCKET_W] !== exp_res.bucket) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("Reply mismatch: status %0d bucket %0d, expected %0d %0d",
                                     m_tdata[cht_pkg::STATUS_W-1:0],
                                     m_tdata[cht_pkg::STATUS_W +: cht_pkg::BUCKET_W],
                                     exp_res.status, exp_res.bucket);
                        end
                    end
                end
                reply_hold = (replies_seen % 256 < 48) ? 0 : $urandom_range(0, 5);
                m_tready   <= (reply_hold == 0);
            end else if (reply_hold > 0) begin
                reply_hold = reply_hold - 1;
                m_tready   <= (reply_hold == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[chained_hash_table_unit] ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < BUCKETS; i++) begin
            bucket_head[i] = NIL_LINK;
        end
        free_top     = 0;
        fresh_count  = 0;
        replies_seen = 0;
        mismatches   = 0;
        cycles       = 0;
        steady       = 1'b0;

        key_set[0] = 32'h0000_0000;
        key_set[1] = 32'hFFFF_FFFF;
        key_set[2] = 32'h7FFF_FFFF;
        key_set[3] = 32'h8000_0000;
        key_set[4] = 32'd9;
        key_set[5] = 32'd10;
        key_set[6] = -32'sd10;
        key_set[7] = -32'sd11;
        for (int i = 8; i < KEY_SET_SIZE; i++) begin
            key_set[i] = (i % 2 == 0) ? cht_pkg::key_t'($urandom)
                                      : cht_pkg::key_t'($urandom_range(0, 60) - 30);
        end

        queue_request(cht_pkg::ACT_INSERT, 32'd0);
        queue_request(cht_pkg::ACT_SEARCH, 32'd0);
        queue_request(cht_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        queue_request(cht_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        queue_request(cht_pkg::ACT_INSERT, 32'h8000_0000);
        queue_request(cht_pkg::ACT_SEARCH, 32'hFFFF_FFFF);
        queue_request(cht_pkg::ACT_SEARCH, 32'h8000_0000);
        queue_request(cht_pkg::ACT_SEARCH, 32'd10);
        queue_request(cht_pkg::ACT_INSERT, 32'd10);
        queue_request(cht_pkg::ACT_INSERT, 32'd0);
        queue_request(cht_pkg::ACT_DELETE, 32'd0);
        queue_request(cht_pkg::ACT_SEARCH, 32'd0);
        queue_request(cht_pkg::ACT_DELETE, 32'd0);
        queue_request(cht_pkg::ACT_SEARCH, 32'd0);
        queue_request(cht_pkg::ACT_DELETE, 32'd0);
        queue_request(cht_pkg::ACT_DELETE, 32'd10);
        queue_request(ACT_UNUSED, -32'sd11);
        queue_request(cht_pkg::ACT_INSERT, -32'sd11);
        queue_request(cht_pkg::ACT_INSERT, 32'd9);
        queue_request(cht_pkg::ACT_DELETE, 32'hFFFF_FFFF);
        queue_request(cht_pkg::ACT_SEARCH, -32'sd11);
        queue_request(cht_pkg::ACT_DELETE, -32'sd11);
        queue_request(cht_pkg::ACT_INSERT, 32'd20);
        queue_request(cht_pkg::ACT_SEARCH, 32'h7FFF_FFFF);

        // Each round fills the pool past exhaustion, mixes, then empties much of it.
        for (int round = 0; round < 3; round++) begin
            steady = (round == 1);
            queue_random(350, 85, 7, 6);
            steady = 1'b0;
            queue_random(200, 34, 33, 31);
            steady = (round == 2);
            queue_random(150, 10, 20, 68);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(posedge aclk);
        end while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("[chained_hash_table_unit] OK");
        end else begin
            $display("[chained_hash_table_unit] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/cht_hash.sv
rtl/chained_hash_table_unit.sv
tb/chained_hash_table_unit_tb.sv
